// File: hdl/tpad_pkg.sv
// Shared types and constants for the phase-angle triac dimmer core.
// Depends on nothing; used by triac_phase_angle_dimmer_core.
package tpad_pkg;

   // Item kind carried on the request tuser bit.
   typedef enum logic [0:0] {
      KIND_TICK       = 1'b0,
      KIND_ZERO_CROSS = 1'b1
   } kind_type;

   localparam int          LEVEL_W        = 7;
   localparam int          COUNT_W        = 16;
   localparam int          PULSE_W        = 8;
   localparam int          STEP_W         = 9;
   localparam int          HALF_W         = 15;

   localparam logic [LEVEL_W-1:0] FULL_LEVEL  = 7'd99;
   localparam logic [COUNT_W-1:0] TIMER_TOP   = 16'hFFFF;
   localparam int                 StepDivisor = 110;

   // Reciprocal of 110 scaled by 2^22; exact for every 15-bit dividend.
   localparam logic [15:0] RECIP_MULT  = 16'd38131;
   localparam int          RECIP_SHIFT = 22;

   localparam int PULSE_TICKS_DEF      = 20;
   localparam int AVG_SAMPLES_LOG2_DEF = 4;

   // One firing step: (mean / 2) / 110 as a multiply by the reciprocal.
   function automatic logic [STEP_W-1:0] step_of_mean(input logic [COUNT_W-1:0] mean);
      logic [HALF_W-1:0] half;
      logic [30:0]       prod;
      half = mean[COUNT_W-1:1];
      prod = 31'(half) * 31'(RECIP_MULT);
      return prod[RECIP_SHIFT +: STEP_W];
   endfunction

endpackage

// File: hdl/triac_phase_angle_dimmer_core.sv
// Phase-angle triac dimmer core: input register, one update step, result register.
// A request waits in the input register until the result register is free, then is registered as a result.
// Throughput: one item per cycle, limited only by the result register handshake.
// Reset (synchronous, active high) clears both pipeline stages and all dimmer state.
// The firing step (mean/2)/110 is recomputed whenever the period average updates.
module triac_phase_angle_dimmer_core
   import tpad_pkg::*;
#(
   parameter int PULSE_TICKS      = PULSE_TICKS_DEF,
   parameter int AVG_SAMPLES_LOG2 = AVG_SAMPLES_LOG2_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [6:0] level, [7] zero
   input  logic        req_tuser,  // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // [0] gate, [1] fired, [17:2] period_avg, [23:18] zero
);

   localparam int SUM_W = COUNT_W + AVG_SAMPLES_LOG2;

   // Input register stage.
   logic               s1_valid_ff, s1_valid_in;
   kind_type           s1_kind_ff;
   logic [LEVEL_W-1:0] s1_level_ff;
   logic               rsp_free;
   logic               process;

   // Dimmer state.
   logic [COUNT_W-1:0]          period_count_ff, period_count_in;
   logic [SUM_W-1:0]            period_sum_ff, period_sum_in;
   logic [AVG_SAMPLES_LOG2-1:0] sample_index_ff, sample_index_in;
   logic [COUNT_W-1:0]          period_mean_ff, period_mean_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic [COUNT_W-1:0]          fire_timer_ff, fire_timer_in;
   logic                        timer_running_ff, timer_running_in;
   logic [PULSE_W-1:0]          pulse_left_ff, pulse_left_in;
   logic                        hold_high_ff, hold_high_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               gate_ff;
   logic               fired_ff, fired_in;
   logic [COUNT_W-1:0] avg_ff;

   // Step datapath helpers.
   logic [LEVEL_W-1:0] level_sat;
   logic [SUM_W-1:0]   sum_next;
   logic [15:0]        step_prod;
   logic [16:0]        load_wide;
   logic [COUNT_W-1:0] load_val;

   assign rsp_free    = !rsp_valid_ff || rsp_tready;
   assign process     = s1_valid_ff && rsp_free;
   assign req_tready  = !s1_valid_ff || rsp_free;
   assign s1_valid_in = (req_tvalid && req_tready) ? 1'b1 : (process ? 1'b0 : s1_valid_ff);

   // Input stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_tvalid && req_tready) begin
         s1_kind_ff  <= kind_type'(req_tuser);
         s1_level_ff <= req_tdata[LEVEL_W-1:0];
      end
   end

   // Timer load value from the stored step and the item level.
   always_comb begin
      level_sat = (s1_level_ff > FULL_LEVEL) ? FULL_LEVEL : s1_level_ff;
      step_prod = 16'(step_ff) * 16'(level_sat);
      load_wide = 17'(TIMER_TOP) - 17'(period_mean_ff[COUNT_W-1:1]) + 17'(step_prod);
      load_val  = (load_wide > 17'(TIMER_TOP)) ? TIMER_TOP : load_wide[COUNT_W-1:0];
      sum_next  = period_sum_ff + SUM_W'(period_count_ff);
   end

   // Next state for one item.
   always_comb begin
      period_count_in  = period_count_ff;
      period_sum_in    = period_sum_ff;
      sample_index_in  = sample_index_ff;
      period_mean_in   = period_mean_ff;
      step_in          = step_ff;
      fire_timer_in    = fire_timer_ff;
      timer_running_in = timer_running_ff;
      pulse_left_in    = pulse_left_ff;
      hold_high_in     = hold_high_ff;
      fired_in         = 1'b0;
      unique case (s1_kind_ff)
         KIND_TICK: begin
            if (period_count_ff != TIMER_TOP) begin
               period_count_in = period_count_ff + 1'b1;
            end
            if (pulse_left_ff != '0) begin
               pulse_left_in = pulse_left_ff - 1'b1;
            end
            if (timer_running_ff) begin
               if (fire_timer_ff == TIMER_TOP) begin
                  fire_timer_in    = '0;
                  timer_running_in = 1'b0;
                  fired_in         = 1'b1;
                  pulse_left_in    = PULSE_W'(PULSE_TICKS);
               end else begin
                  fire_timer_in = fire_timer_ff + 1'b1;
               end
            end
         end
         KIND_ZERO_CROSS: begin
            if (level_sat == FULL_LEVEL || level_sat == '0 || period_mean_ff == '0) begin
               // Fully on or off, or no period average yet: take an averaging sample.
               if (level_sat == FULL_LEVEL) begin
                  hold_high_in = 1'b1;
               end else begin
                  hold_high_in  = 1'b0;
                  pulse_left_in = '0;
               end
               period_count_in = '0;
               if (sample_index_ff == '1) begin
                  period_mean_in  = sum_next[AVG_SAMPLES_LOG2 +: COUNT_W];
                  step_in         = step_of_mean(period_mean_in);
                  period_sum_in   = '0;
                  sample_index_in = '0;
               end else begin
                  period_sum_in   = sum_next;
                  sample_index_in = sample_index_ff + 1'b1;
               end
            end else begin
               // Dimming: arm the firing timer.
               hold_high_in     = 1'b0;
               pulse_left_in    = '0;
               fire_timer_in    = load_val;
               timer_running_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = process ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // State and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_count_ff  <= '0;
         period_sum_ff    <= '0;
         sample_index_ff  <= '0;
         period_mean_ff   <= '0;
         step_ff          <= '0;
         fire_timer_ff    <= '0;
         timer_running_ff <= 1'b0;
         pulse_left_ff    <= '0;
         hold_high_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (process) begin
            period_count_ff  <= period_count_in;
            period_sum_ff    <= period_sum_in;
            sample_index_ff  <= sample_index_in;
            period_mean_ff   <= period_mean_in;
            step_ff          <= step_in;
            fire_timer_ff    <= fire_timer_in;
            timer_running_ff <= timer_running_in;
            pulse_left_ff    <= pulse_left_in;
            hold_high_ff     <= hold_high_in;
         end
      end
      if (process) begin
         gate_ff  <= hold_high_in || (pulse_left_in != '0);
         fired_ff <= fired_in;
         avg_ff   <= period_mean_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, avg_ff, fired_ff, gate_ff};

`ifndef SYNTHESIS
   // The stored step always matches the current period average: step * 110 <= half and
   // half < (step + 1) * 110.
   a_step_matches_mean: assert property (@(posedge clock) disable iff (reset)
      (32'(step_ff) * StepDivisor <= 32'(period_mean_ff[COUNT_W-1:1])) &&
      (32'(period_mean_ff[COUNT_W-1:1]) < (32'(step_ff) + 1) * StepDivisor))
      else $error("firing step out of sync with period average");

   // A stopped timer always rests at zero.
   a_stopped_timer_zero: assert property (@(posedge clock) disable iff (reset)
      !timer_running_ff |-> fire_timer_ff == '0)
      else $error("stopped firing timer is not zero");

   // The gate pulse counter never exceeds its load value.
   a_pulse_bound: assert property (@(posedge clock) disable iff (reset)
      32'(pulse_left_ff) <= PULSE_TICKS)
      else $error("gate pulse counter above pulse length");

   // A fired result always reports the gate high.
   a_fired_gate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && fired_ff) |-> gate_ff)
      else $error("timer fired without driving the gate");

   // A processed item always produces a valid result on the next edge.
   a_process_result: assert property (@(posedge clock) disable iff (reset)
      process |=> rsp_valid_ff)
      else $error("processed item lost before the result register");
`endif

endmodule
